// File: src/multichannel_moving_average_decimator_core_defines.svh
// ============================================================================
// Assertion macros for the moving average decimator
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef MULTICHANNEL_MOVING_AVERAGE_DECIMATOR_CORE_DEFINES_SVH
`define MULTICHANNEL_MOVING_AVERAGE_DECIMATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge
`define MMAD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define MMAD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define MMAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MMAD_ASSERT_ALWAYS(label, cond, msg)
`define MMAD_ASSERT_IMPLIES(label, ante, cons, msg)
`define MMAD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: src/mmad_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mmad_pkg
// Shared types and constants of the multichannel moving average decimator.
// ============================================================================
package mmad_pkg;

    // Default configuration
    localparam int CHANNELS_DEF    = 9;
    localparam int WINDOW_DEF      = 50;
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths
    localparam int CHAN_W   = 4;
    localparam int SAMPLE_W = 12;
    localparam int AVG_W    = 12;
    localparam int PERIOD_W = 10;

    // Update period after reset
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd10;

    // Depth of the command queue between front and back
    localparam int CMD_DEPTH = 4;

    // Input transaction
    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
    } item_t;

    // Result transaction
    typedef struct packed {
        logic [CHAN_W-1:0] out_channel;
        logic [AVG_W-1:0]  average;
        logic              last;
    } result_t;

    // Back end sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_RUN   = 3'b010,
        ST_EMIT  = 3'b100
    } back_state_t;

endpackage

// File: src/multichannel_moving_average_decimator_core.sv
`timescale 1ns / 1ps
// ============================================================================
// multichannel_moving_average_decimator_core
// Per-channel boxcar average over WINDOW frames, emitted every update period.
// ============================================================================
// Samples are taken one per cycle while the command queue has room: each one
// is a read-modify-write of the history RAM and the channel's running sum over
// two pipeline stages, with a bypass when the same slot is hit twice in a row.
// A frame that reaches the update period stops the back end from taking
// commands while the emitting sample is applied and the reciprocal multiplier
// works through the channels, and longer while the 2*2^clog2(CHANNELS)-entry
// result queue lacks room for the whole burst. With both queues empty, the
// emitting sample goes through the command queue, stage one, the product
// register and the result queue to the result ports. The four-entry command
// queue takes the first samples of that stall and full is raised once it
// fills. After reset all CHANNELS*WINDOW history entries (450 by default)
// are swept to zero with full held high, configuration writes still taken.
// ============================================================================
`include "multichannel_moving_average_decimator_core_defines.svh"

module multichannel_moving_average_decimator_core #(
    parameter int CHANNELS    = mmad_pkg::CHANNELS_DEF,
    parameter int WINDOW      = mmad_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = mmad_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  mmad_pkg::item_t               item,
    output logic                          full,
    input  logic                          pop,
    output mmad_pkg::result_t             result,
    output logic                          empty,
    input  logic                          cfg_we,
    input  logic [mmad_pkg::PERIOD_W-1:0] cfg_wdata
);

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W    = $clog2(CHANNELS * WINDOW);
    localparam int CMD_W     = CH_W + SAMPLE_BITS + ADDR_W + 1;
    localparam int RES_DEPTH = 2 * (2 ** $clog2(CHANNELS));
    localparam int RES_W     = $bits(mmad_pkg::result_t);
    localparam int RCNT_W    = $clog2(RES_DEPTH + 1);

    logic                 busy;
    logic                 cmd_push;
    logic [CMD_W-1:0]     cmd_data;
    logic                 cmd_full;
    logic                 cmd_pop;
    logic [CMD_W-1:0]     cmd_head;
    logic                 cmd_empty;
    logic                 res_push;
    mmad_pkg::result_t    res_data;
    logic                 res_full;
    logic [RES_W-1:0]     res_dout;
    logic [RCNT_W-1:0]    res_count;

    // Front: accept and classify
    mmad_front #(
        .CHANNELS    (CHANNELS),
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .busy      (busy),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd_data  (cmd_data)
    );

    // Command queue between front and back
    mmad_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (mmad_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_data),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_head),
        .empty (cmd_empty),
        .count ()
    );

    // Back: history update and averaged burst
    mmad_back #(
        .CHANNELS    (CHANNELS),
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .RES_DEPTH   (RES_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_count (res_count),
        .res_push  (res_push),
        .res_data  (res_data),
        .busy      (busy)
    );

    // Result queue
    mmad_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_data),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_dout),
        .empty (empty),
        .count (res_count)
    );

    assign result = mmad_pkg::result_t'(res_dout);

    // Checks
    `MMAD_ASSERT_IMPLIES(a_res_no_overflow, res_push, !res_full, "result queue overflow")
    `MMAD_ASSERT_IMPLIES(a_last_channel, !empty && result.last,
        32'(result.out_channel) == CHANNELS - 1, "last mark on wrong channel")
    `MMAD_ASSERT_NEXT(a_clear_once, !busy, !busy, "history clear restarted")

endmodule

// File: src/mmad_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// mmad_ram
// Generic single write, single read RAM with registered read data.
// ============================================================================
module mmad_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 450,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port (read returns old data on collision)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/mmad_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// mmad_fifo
// Small register queue with occupancy count; depth is a power of two.
// ============================================================================
module mmad_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty,
    output logic [CNT_W-1:0] count
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];
    assign count   = count_reg;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// File: src/mmad_front.sv
`timescale 1ns / 1ps
// ============================================================================
// mmad_front
// Accepts samples, drops unknown channels, tracks the write slot and the
// frame counter, and queues one history update command per valid sample.
// ============================================================================
module mmad_front #(
    parameter int CHANNELS    = mmad_pkg::CHANNELS_DEF,
    parameter int WINDOW      = mmad_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = mmad_pkg::SAMPLE_BITS_DEF,
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int WP_W   = $clog2(WINDOW),
    localparam int ADDR_W = $clog2(CHANNELS * WINDOW),
    localparam int CMD_W  = CH_W + SAMPLE_BITS + ADDR_W + 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  mmad_pkg::item_t                 item,
    output logic                            full,
    input  logic                            cfg_we,
    input  logic [mmad_pkg::PERIOD_W-1:0]   cfg_wdata,
    input  logic                            busy,
    input  logic                            cmd_full,
    output logic                            cmd_push,
    output logic [CMD_W-1:0]                cmd_data
);

    typedef struct packed {
        logic [CH_W-1:0]        ch;
        logic [SAMPLE_BITS-1:0] smp;
        logic [ADDR_W-1:0]      addr;
        logic                   emit;
    } cmd_t;

    logic [mmad_pkg::PERIOD_W-1:0] period_reg;
    logic [WP_W-1:0]               wp_reg;
    logic [WP_W-1:0]               wp_next;
    logic [mmad_pkg::PERIOD_W-1:0] fc_reg;
    logic [mmad_pkg::PERIOD_W-1:0] fc_next;
    logic [mmad_pkg::PERIOD_W-1:0] fc_inc;
    logic                          accept;
    logic                          in_range;
    logic                          frame_end;
    logic                          emit;
    logic [CH_W-1:0]               ch;
    logic [31:0]                   smp_wide;
    cmd_t                          cmd;

    // Handshake: hold off while the command queue is full or the history is being cleared
    assign full   = cmd_full || busy;
    assign accept = push && !full;

    // Classify the transaction
    assign in_range  = (32'(item.channel) < CHANNELS);
    assign ch        = item.channel[CH_W-1:0];
    assign frame_end = in_range && (ch == CH_W'(CHANNELS - 1));
    assign fc_inc    = fc_reg + mmad_pkg::PERIOD_W'(1);
    assign emit      = frame_end && (fc_inc >= period_reg);

    // Slot position and frame counter after a completed frame
    assign wp_next = (wp_reg == WP_W'(WINDOW - 1)) ? '0 : wp_reg + WP_W'(1);
    assign fc_next = emit ? '0 : fc_inc;

    // Update command
    assign smp_wide = 32'(item.sample);
    always_comb
    begin
        cmd.ch   = ch;
        cmd.smp  = smp_wide[SAMPLE_BITS-1:0];
        cmd.addr = ADDR_W'(32'(ch) * WINDOW + 32'(wp_reg));
        cmd.emit = emit;
    end

    assign cmd_push = accept && in_range;
    assign cmd_data = cmd;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= mmad_pkg::PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            period_reg <= cfg_wdata;
        end
    end

    // Frame tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            fc_reg <= '0;
        end
        else if (accept && frame_end)
        begin
            wp_reg <= wp_next;
            fc_reg <= fc_next;
        end
    end

endmodule

// File: src/mmad_back.sv
`timescale 1ns / 1ps
// ============================================================================
// mmad_back
// Clears the history after reset, applies update commands as a two-stage
// read-modify-write of history and running sums, and produces the averaged
// burst through a reciprocal multiply.
// ============================================================================
module mmad_back #(
    parameter int CHANNELS    = mmad_pkg::CHANNELS_DEF,
    parameter int WINDOW      = mmad_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = mmad_pkg::SAMPLE_BITS_DEF,
    parameter int RES_DEPTH   = 32,
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int HIST_DEPTH = CHANNELS * WINDOW,
    localparam int ADDR_W     = $clog2(HIST_DEPTH),
    localparam int CMD_W      = CH_W + SAMPLE_BITS + ADDR_W + 1,
    localparam int RCNT_W     = $clog2(RES_DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_empty,
    input  logic [CMD_W-1:0]     cmd_head,
    output logic                 cmd_pop,
    input  logic [RCNT_W-1:0]    res_count,
    output logic                 res_push,
    output mmad_pkg::result_t    res_data,
    output logic                 busy
);

    // Exact division by WINDOW: q = (x * MULT) >> SHIFT for every SUM_W-bit x
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int SHIFT  = SUM_W + $clog2(WINDOW);
    localparam int MULT_W = SUM_W + 1;
    localparam int PROD_W = SUM_W + MULT_W;
    localparam longint unsigned MULT = ((64'd1 << SHIFT) / WINDOW) + 64'd1;

    typedef struct packed {
        logic [CH_W-1:0]        ch;
        logic [SAMPLE_BITS-1:0] smp;
        logic [ADDR_W-1:0]      addr;
        logic                   emit;
    } cmd_t;

    mmad_pkg::back_state_t  state_reg;
    mmad_pkg::back_state_t  state_next;
    logic [ADDR_W-1:0]      clr_addr_reg;
    cmd_t                   head;
    logic                   issue;

    logic                   s1_valid_reg;
    cmd_t                   s1_cmd_reg;
    logic                   s1_byp_reg;
    logic [SAMPLE_BITS-1:0] s1_byp_data_reg;
    logic                   byp;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic [SAMPLE_BITS-1:0] old_smp;

    logic [SUM_W-1:0]       sum_reg [CHANNELS];
    logic [CH_W-1:0]        sum_idx;
    logic [SUM_W-1:0]       sum_rd;
    logic [SUM_W-1:0]       sum_new;

    logic [CH_W-1:0]        k_reg;
    logic                   k_last;
    logic                   space_ok;
    logic                   emit_fire;
    logic                   prod_valid_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [PROD_W-1:0]      prod_next;
    logic [CH_W-1:0]        prod_ch_reg;
    logic                   prod_last_reg;
    logic [PROD_W-1:0]      quot;

    assign head = cmd_t'(cmd_head);
    assign busy = (state_reg == mmad_pkg::ST_CLEAR);

    // Issue: no new command while the burst is pending or running
    assign issue   = (state_reg == mmad_pkg::ST_RUN) && !cmd_empty &&
                     !(s1_valid_reg && s1_cmd_reg.emit);
    assign cmd_pop = issue;

    // Same slot written by the stage ahead: RAM read still returns old data
    assign byp = s1_valid_reg && (s1_cmd_reg.addr == head.addr);

    // History RAM: clear sweep or stage-one write
    assign ram_we    = busy || s1_valid_reg;
    assign ram_waddr = busy ? clr_addr_reg : s1_cmd_reg.addr;
    assign ram_wdata = busy ? '0 : s1_cmd_reg.smp;

    mmad_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head.addr),
        .rdata (ram_rdata)
    );

    // Running sum read port, shared by update and burst
    assign sum_idx = (state_reg == mmad_pkg::ST_EMIT) ? k_reg : s1_cmd_reg.ch;
    assign sum_rd  = sum_reg[sum_idx];
    assign old_smp = s1_byp_reg ? s1_byp_data_reg : ram_rdata;
    assign sum_new = sum_rd - SUM_W'(old_smp) + SUM_W'(s1_cmd_reg.smp);

    // Burst: reserve room for all results before the first one
    assign space_ok  = (32'(res_count) + 32'(prod_valid_reg) + CHANNELS) <= RES_DEPTH;
    assign emit_fire = (state_reg == mmad_pkg::ST_EMIT) && ((k_reg != '0) || space_ok);
    assign k_last    = (k_reg == CH_W'(CHANNELS - 1));
    assign prod_next = {{MULT_W{1'b0}}, sum_rd} * PROD_W'(MULT);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mmad_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(HIST_DEPTH - 1))
                begin
                    state_next = mmad_pkg::ST_RUN;
                end
            end
            mmad_pkg::ST_RUN:
            begin
                if (s1_valid_reg && s1_cmd_reg.emit)
                begin
                    state_next = mmad_pkg::ST_EMIT;
                end
            end
            mmad_pkg::ST_EMIT:
            begin
                if (emit_fire && k_last)
                begin
                    state_next = mmad_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = mmad_pkg::ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mmad_pkg::ST_CLEAR;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            k_reg          <= '0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            s1_valid_reg   <= issue;
            prod_valid_reg <= emit_fire;
            if (busy)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (emit_fire)
            begin
                k_reg <= k_last ? '0 : k_reg + CH_W'(1);
            end
        end
    end

    // Stage one payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_cmd_reg      <= head;
            s1_byp_reg      <= byp;
            s1_byp_data_reg <= s1_cmd_reg.smp;
        end
    end

    // Running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            sum_reg[s1_cmd_reg.ch] <= sum_new;
        end
    end

    // Product register of the burst pipeline
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            prod_reg      <= prod_next;
            prod_ch_reg   <= k_reg;
            prod_last_reg <= k_last;
        end
    end

    // Result transaction
    assign quot     = prod_reg >> SHIFT;
    assign res_push = prod_valid_reg;
    always_comb
    begin
        res_data.out_channel = mmad_pkg::CHAN_W'(prod_ch_reg);
        res_data.average     = quot[mmad_pkg::AVG_W-1:0];
        res_data.last        = prod_last_reg;
    end

endmodule
